### hdl/weighted_urn_sampler_assert.svh
// assertion macros for the weighted urn sampler
// expects clk and active-low rst_n in the scope of each use
`ifndef WEIGHTED_URN_SAMPLER_ASSERT_SVH
`define WEIGHTED_URN_SAMPLER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WUR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted_urn_sampler check failed");

// next-cycle implication, disabled during reset
`define WUR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted_urn_sampler check failed");

`endif

### hdl/wur_pkg.sv
// shared types and constants of the weighted urn sampler
// no dependencies
`timescale 1ns / 1ps

package wur_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    localparam logic [CNT_W-1:0] TYPE_COUNT_RESET = 5'd16;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_WALK,
        ST_DONE
    } wur_state_t;

endpackage

### hdl/wur_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module wur_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/weighted_urn_sampler.sv
// weighted urn sampler top level: sequencer, shared multiplier and walk adder
// depends on wur_pkg, wur_ram and weighted_urn_sampler_assert.svh
`timescale 1ns / 1ps

// Usage
//   s_* carries one item: s_tuser is the operation (0 add, 1 select), s_tdata
//   packs type_index, amount, draw from bit 0 up. An add item for a type in
//   use raises its count (saturating) and the running total; it gives no result.
//   A select item gives one result on m_*: m_tdata[4:0] is the chosen type,
//   or the number of types in use when none qualifies.
//   cfg_we/cfg_wdata write the number of types in use; write only when idle.
// Sequencing
//   s_tready is high only while the sequencer is idle. An add reads the ram,
//   registers the read data and writes back. A select makes two passes
//   through the 32x32 multiplier for draw * total, then takes one stored
//   count per cycle through the cumulative adder and compare, then loads the
//   output register. An empty urn or zero types goes straight to the output
//   register.
// Reset and stalls
//   reset clears all counts (per-entry valid bits), the total and the output
//   valid flag, and sets the type count to 16. A result waits in the output
//   register; a stalled receiver holds the sequencer in its final state.

module weighted_urn_sampler
    import wur_pkg::*;
#(
    parameter int MAX_TYPES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // type_index[3:0], amount[35:4], draw[67:36]
    input  logic                 s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // selected[4:0]
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(MAX_TYPES);
    localparam int TW = DATA_W + AW;
    localparam logic [8:0] MAX_W9 = 9'(MAX_TYPES);

    wur_state_t state_reg, state_next;

    logic [CNT_W-1:0]    type_count_reg;
    logic [CNT_W-1:0]    n_eff;
    logic [TW-1:0]       total_reg;
    logic [MAX_TYPES-1:0] valid_reg;
    logic                rd_valid_reg;

    logic [IDX_W-1:0]    idx_reg;
    logic [DATA_W-1:0]   amount_reg;
    logic [DATA_W-1:0]   draw_reg;
    logic [2*DATA_W-1:0] p0_reg;
    logic [TW-1:0]       hi_reg;
    logic                lo_zero_reg;
    logic [TW-1:0]       cum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    result_reg;

    logic                m_tvalid_reg;
    logic [CNT_W-1:0]    sel_reg;

    logic [IDX_W-1:0]    in_idx;
    logic [DATA_W-1:0]   in_amount;
    logic [DATA_W-1:0]   in_draw;
    logic                accept;
    logic                idx_in_use;
    logic                out_free;

    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                ram_we;
    logic [DATA_W-1:0]   rd_data;
    logic [DATA_W-1:0]   stored;
    logic                rd_addr_ok;

    logic [DATA_W:0]     add_sum;
    logic [DATA_W-1:0]   add_sat;
    logic [DATA_W-1:0]   mul_b;
    logic [2*DATA_W-1:0] mul_p;
    logic [TW-1:0]       cum_next;
    logic                hit;
    logic                last;

    assign in_idx    = s_tdata[3:0];
    assign in_amount = s_tdata[35:4];
    assign in_draw   = s_tdata[67:36];

    assign n_eff      = (9'(type_count_reg) > MAX_W9) ? CNT_W'(MAX_TYPES) : type_count_reg;
    assign idx_in_use = CNT_W'(in_idx) < n_eff;
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    // stored count, unwritten entries read as zero
    assign stored  = rd_valid_reg ? rd_data : '0;
    assign add_sum = {1'b0, stored} + {1'b0, amount_reg};
    assign add_sat = add_sum[DATA_W] ? '1 : add_sum[DATA_W-1:0];

    // shared multiplier: low then high half of the total
    assign mul_b = (state_reg == ST_MUL_LO) ? total_reg[DATA_W-1:0]
                                            : DATA_W'(total_reg[TW-1:DATA_W]);
    assign mul_p = draw_reg * mul_b;

    assign cum_next = cum_reg + TW'(stored);
    assign hit      = lo_zero_reg ? (cum_next >= hi_reg) : (cum_next > hi_reg);
    assign last     = (cnt_reg + 1'b1) == n_eff;

    wur_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_TYPES)
    ) u_counts (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_addr),
        .wdata(add_sat),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_ADD)
                    begin
                        state_next = idx_in_use ? ST_ADD_RD : ST_IDLE;
                    end
                    else if (total_reg == '0 || n_eff == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL_LO;
                    end
                end
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR: state_next = ST_IDLE;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_WALK;
            ST_WALK:
            begin
                if (hit || last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
        rd_addr  = AW'(idx_reg);
        wr_addr  = AW'(idx_reg);
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_ADD_WR: ram_we   = 1'b1;
            ST_MUL_HI: rd_addr  = '0;
            ST_WALK:   rd_addr  = AW'(cnt_reg + 1'b1);
            default:   ;
        endcase
    end

    assign rd_addr_ok = 32'(rd_addr) < MAX_TYPES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            type_count_reg <= TYPE_COUNT_RESET;
            total_reg      <= '0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_addr_ok && valid_reg[rd_addr];
            if (cfg_we)
            begin
                type_count_reg <= cfg_wdata;
            end
            if (state_reg == ST_ADD_WR)
            begin
                total_reg          <= total_reg + TW'(add_sat - stored);
                valid_reg[wr_addr] <= 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_reg    <= in_idx;
                    amount_reg <= in_amount;
                    draw_reg   <= in_draw;
                    cnt_reg    <= '0;
                    cum_reg    <= '0;
                    // empty urn: a zero draw picks type 0 when any type is in use
                    result_reg <= (total_reg == '0 && in_draw == '0 && n_eff != '0)
                                  ? '0 : n_eff;
                end
            end
            ST_MUL_LO: p0_reg <= mul_p;
            ST_MUL_HI:
            begin
                hi_reg      <= TW'(mul_p) + TW'(p0_reg[2*DATA_W-1:DATA_W]);
                lo_zero_reg <= p0_reg[DATA_W-1:0] == '0;
            end
            ST_WALK:
            begin
                cum_reg <= cum_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (hit)
                begin
                    result_reg <= cnt_reg;
                end
                else if (last)
                begin
                    result_reg <= n_eff;
                end
            end
            default: ;
        endcase
        if (state_reg == ST_DONE && out_free)
        begin
            sel_reg <= result_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(sel_reg);

`include "weighted_urn_sampler_assert.svh"

    `WUR_ASSERT_IMPL(a_walk_nonempty, (state_reg == ST_WALK), (total_reg != '0))
    `WUR_ASSERT_IMPL(a_walk_in_range, (state_reg == ST_WALK), (cnt_reg < n_eff))
    `WUR_ASSERT_NEXT(a_result_from_done, (state_reg != ST_DONE && !m_tvalid_reg), (!m_tvalid_reg))

endmodule

### test/weighted_urn_sampler_tb.sv
// self-checking bench for weighted_urn_sampler: directed and random add/select items
// with bursty input, stalling output and type count changes between phases
// depends on wur_pkg and the weighted_urn_sampler rtl
`timescale 1ns / 1ps

module weighted_urn_sampler_tb;
    import wur_pkg::*;

    localparam int NTYPES = 16;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  type_index;
        logic [DATA_W-1:0] amount;
        logic [DATA_W-1:0] draw;
    } urn_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic [CNT_W-1:0]     cfg_wdata;

    urn_item_t         pending_items[$];
    logic [4:0]        expected_picks[$];
    urn_item_t         item_on_bus;
    logic [4:0]        want_pick;

    // predictor state
    logic [DATA_W-1:0] urn_count [NTYPES];
    logic [35:0]       urn_total;
    logic [CNT_W-1:0]  types_in_use;

    int burst_left;
    int gap_left;
    int gap_max;
    int stall_mode;
    int stall_left;
    int mismatches;

    weighted_urn_sampler #(
        .MAX_TYPES(NTYPES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic logic [4:0] live_types();
        return (types_in_use > NTYPES) ? 5'(NTYPES) : types_in_use;
    endfunction

    task automatic deposit(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] amt);
        logic [32:0] sum;
        if (idx < live_types())
        begin
            sum = {1'b0, urn_count[idx]} + {1'b0, amt};
            if (sum[32])
                sum = 33'h0_FFFF_FFFF;
            // total grows only by what the count really took
            urn_total = urn_total + 36'(sum) - 36'(urn_count[idx]);
            urn_count[idx] = sum[31:0];
        end
    endtask

    // first type whose cumulative count * 2^32 reaches draw * total
    function automatic logic [4:0] pick_type(input logic [DATA_W-1:0] draw);
        logic [4:0]  n;
        logic [35:0] cum;
        logic [71:0] scaled_draw;
        logic [71:0] scaled_cum;
        n = live_types();
        if (urn_total == 0)
            return (draw == 0 && n != 0) ? 5'd0 : n;
        cum = '0;
        scaled_draw = 72'(draw) * 72'(urn_total);
        for (int i = 0; i < NTYPES; i++)
        begin
            if (i >= n)
                break;
            cum = cum + 36'(urn_count[i]);
            scaled_cum = 72'({cum, 32'h0});
            if (scaled_cum >= scaled_draw)
                return 5'(i);
        end
        return n;
    endfunction

    // sender: bursts of items with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (item_on_bus.op == OP_SELECT)
                    expected_picks.push_back(pick_type(item_on_bus.draw));
                else
                    deposit(item_on_bus.type_index, item_on_bus.amount);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || pending_items.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    item_on_bus = pending_items.pop_front();
                    s_tdata  <= {4'b0, item_on_bus.draw, item_on_bus.amount,
                                 item_on_bus.type_index};
                    s_tuser  <= item_on_bus.op;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(12, 1);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
                    end
                end
            end
        end
    end

    // receiver: stall pattern set per phase, result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_picks.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected: selected %0d",
                             $time, m_tdata[4:0]);
                end
                else
                begin
                    want_pick = expected_picks.pop_front();
                    if (m_tdata[4:0] !== want_pick)
                    begin
                        mismatches++;
                        $display("%0t: selected mismatch: expected %0d actual %0d",
                                 $time, want_pick, m_tdata[4:0]);
                    end
                end
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(1, 0));
                default:
                begin
                    // long stalls now and then
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end
                    else if ($urandom_range(7, 0) == 0)
                    begin
                        stall_left = $urandom_range(30, 1);
                        m_tready <= 1'b0;
                    end
                    else
                        m_tready <= 1'b1;
                end
            endcase
        end
    end

    task automatic queue_item(input logic op, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] amt, input logic [DATA_W-1:0] drw);
        urn_item_t it;
        it.op = op;
        it.type_index = idx;
        it.amount = amt;
        it.draw = drw;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_picks.size() != 0);
        // an add may still be writing back
        repeat (8) @(negedge clk);
    endtask

    task automatic set_type_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        types_in_use = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] tc, input int count, input int amount_bits,
                             input int gmax, input int smode);
        urn_item_t   it;
        logic [31:0] amount_mask;
        set_type_count(tc);
        gap_max = gmax;
        stall_mode = smode;
        amount_mask = (amount_bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << amount_bits) - 1);
        for (int k = 0; k < count; k++)
        begin
            it.op = ($urandom_range(99, 0) < 45) ? OP_SELECT : OP_ADD;
            it.type_index = IDX_W'($urandom_range(15, 0));
            it.amount = $urandom & amount_mask;
            if (amount_bits >= 32 && $urandom_range(9, 0) == 0)
                it.amount = 32'hFFFF_FFFF;
            case ($urandom_range(9, 0))
                0:       it.draw = 32'h0;
                1:       it.draw = 32'hFFFF_FFFF;
                default: it.draw = $urandom;
            endcase
            pending_items.push_back(it);
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        types_in_use = TYPE_COUNT_RESET;
        urn_total = '0;
        foreach (urn_count[i])
            urn_count[i] = '0;
        burst_left = 0;
        gap_left = 0;
        gap_max = 0;
        stall_mode = 0;
        stall_left = 0;
        mismatches = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty urn, zero amount, small adds
        gap_max = 2;
        stall_mode = 1;
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h1);
        queue_item(OP_SELECT, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(OP_ADD, 4'd0, 32'h0, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h8000_0000);
        queue_item(OP_ADD, 4'd0, 32'h100, 32'hFFFF_FFFF);
        queue_item(OP_ADD, 4'd7, 32'h80, 32'h0);
        queue_item(OP_ADD, 4'd15, 32'h1, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h1);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'hAAAA_AAAA);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'hFFFF_FFFF);
        wait_drained();

        // no types in use: every select answers 0, adds are dropped
        set_type_count(5'd0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h5);
        queue_item(OP_ADD, 4'd0, 32'h5, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'hFFFF_FFFF);
        wait_drained();

        // one type: mass of the others is unclaimable
        set_type_count(5'd1);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'hFFFF_FFFF);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h0);
        queue_item(OP_ADD, 4'd3, 32'h40, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h4000_0000);
        wait_drained();

        run_phase(5'd31, 60, 16, 4, 1);
        run_phase(5'd5, 60, 12, 0, 0);
        run_phase(5'd16, 60, 20, 8, 2);
        run_phase(5'd9, 60, 16, 2, 2);
        run_phase(5'd2, 55, 16, 0, 1);
        run_phase(5'd17, 55, 8, 6, 0);
        run_phase(5'd12, 55, 24, 3, 2);

        // saturation of one count; the total grows only by what the count took
        set_type_count(5'd16);
        queue_item(OP_ADD, 4'd15, 32'hFFFF_FFFF, 32'h0);
        queue_item(OP_ADD, 4'd15, 32'h1, 32'h0);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'hFFFF_FFFF);
        queue_item(OP_SELECT, 4'd0, 32'h0, 32'h0);
        wait_drained();

        run_phase(5'd16, 120, 32, 5, 2);

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS weighted_urn_sampler");
        else
            $display("FAIL weighted_urn_sampler");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL weighted_urn_sampler");
        $finish;
    end

endmodule
